[rtl/tpa_pkg.sv]
`timescale 1ns / 1ps
package tpa_pkg;

  localparam int COORD_W    = 16;
  localparam int PERIM_W    = 23;
  localparam int AREA_W     = 40;
  localparam int COORD_BITS_DEF = 16;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } tpa_in_t;

  typedef struct packed {
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0]  area;
    logic               degenerate;
  } tpa_out_t;

endpackage

[rtl/triangle_perimeter_area.sv]
`timescale 1ns / 1ps
// channel  | ports                      | handshake
// request  | start, busy, in_data       | taken at an edge with start high and busy low
// result   | out_strobe, out_data       | strobe marks each result, cannot be held off
//
// fully pipelined: one triangle per cycle, busy stays low
// most of the pipeline registers lie in the two square root cell rows,
//   one root bit per cell
// rst_n is synchronous and clears every valid bit; payload registers are not reset
// results come out in request order; the receiver has no way to stall the pipe
module triangle_perimeter_area #(
  parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  tpa_pkg::tpa_in_t in_data,
  output logic             out_strobe,
  output tpa_pkg::tpa_out_t out_data
);
  import tpa_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int XW  = (CB > COORD_W) ? CB : COORD_W;  // sign-extended field width
  localparam int SW  = CB + 5;                          // side length, 4 fraction bits
  localparam int PW  = CB + 7;                          // perimeter and P-2x terms
  localparam int FW  = 2 * PW;                          // heron half products
  localparam int ARW = 2 * FW;                          // heron radicand

  // stage 0: input register, low COORD_BITS of every coordinate
  logic signed [XW-1:0] ext [6];
  logic signed [CB-1:0] crd_r [6];
  logic                 v0_r;

  assign ext[0] = XW'(in_data.ax);
  assign ext[1] = XW'(in_data.ay);
  assign ext[2] = XW'(in_data.bx);
  assign ext[3] = XW'(in_data.by_coord);
  assign ext[4] = XW'(in_data.cx);
  assign ext[5] = XW'(in_data.cy);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      crd_r[i] <= ext[i][CB-1:0];
    end
  end

  function automatic logic [CB-1:0] absdiff(logic signed [CB-1:0] p, logic signed [CB-1:0] q);
    logic signed [CB:0] d;
    logic signed [CB:0] n;
    d = {p[CB-1], p} - {q[CB-1], q};
    n = -d;
    return d[CB] ? n[CB-1:0] : d[CB-1:0];
  endfunction

  // stage 1: |dx|, |dy| for sides a = AB, b = AC, c = BC
  logic [CB-1:0] dx_r [3];
  logic [CB-1:0] dy_r [3];
  logic          v1_r;

  always_ff @(posedge clk) begin
    dx_r[0] <= absdiff(crd_r[0], crd_r[2]);
    dy_r[0] <= absdiff(crd_r[1], crd_r[3]);
    dx_r[1] <= absdiff(crd_r[0], crd_r[4]);
    dy_r[1] <= absdiff(crd_r[1], crd_r[5]);
    dx_r[2] <= absdiff(crd_r[2], crd_r[4]);
    dy_r[2] <= absdiff(crd_r[3], crd_r[5]);
  end

  // stage 2: 256*(dx^2+dy^2) as side radicands
  logic [2*CB-1:0]             sqx [3];
  logic [2*CB-1:0]             sqy [3];
  logic [2:0][2*SW-1:0]        srad_r;
  logic                        v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqx[i] = dx_r[i] * dx_r[i];
      sqy[i] = dy_r[i] * dy_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      srad_r[i] <= (2*SW)'({(2*CB+1)'(sqx[i]) + (2*CB+1)'(sqy[i]), 8'h00});
    end
  end

  // side square roots, three lanes in one row of cells
  logic                sv;
  logic [2:0][SW-1:0]  side;
  logic                s_exact;

  tpa_sqrt_chain #(.LANES(3), .QW(SW)) u_side (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (v2_r),
    .rad_i  (srad_r),
    .v_o    (sv),
    .root_o (side),
    .exact_o(s_exact)
  );

  // stage 3: perimeter, P-2a, P-2b, P-2c and the triangle inequality
  logic [PW-1:0] sa, sb, sc, psum;
  logic [PW-1:0] p3_r, d1_r, d2_r, d3_r;
  logic          dg3_r, v3_r;

  assign sa   = PW'(side[0]);
  assign sb   = PW'(side[1]);
  assign sc   = PW'(side[2]);
  assign psum = sa + sb + sc;

  always_ff @(posedge clk) begin
    p3_r  <= psum;
    d1_r  <= psum - {sa[PW-2:0], 1'b0};
    d2_r  <= psum - {sb[PW-2:0], 1'b0};
    d3_r  <= psum - {sc[PW-2:0], 1'b0};
    // side widths leave headroom, so the pair sums cannot wrap
    dg3_r <= !((sa + sb > sc) && (sa + sc > sb) && (sb + sc > sa));
  end

  // stage 4: f1 = P(P-2a), f2 = (P-2b)(P-2c)
  logic [FW-1:0] f1_r, f2_r;
  logic [PW-1:0] p4_r;
  logic          dg4_r, v4_r;

  always_ff @(posedge clk) begin
    f1_r  <= FW'(p3_r) * FW'(d1_r);
    f2_r  <= FW'(d2_r) * FW'(d3_r);
    p4_r  <= p3_r;
    dg4_r <= dg3_r;
  end

  // stage 5: f1*f2 as four half-width partial products
  logic [FW-1:0] hh_r, hl_r, lh_r, ll_r;
  logic [PW-1:0] p5_r;
  logic          dg5_r, v5_r;

  always_ff @(posedge clk) begin
    hh_r  <= FW'(f1_r[FW-1:PW]) * FW'(f2_r[FW-1:PW]);
    hl_r  <= FW'(f1_r[FW-1:PW]) * FW'(f2_r[PW-1:0]);
    lh_r  <= FW'(f1_r[PW-1:0]) * FW'(f2_r[FW-1:PW]);
    ll_r  <= FW'(f1_r[PW-1:0]) * FW'(f2_r[PW-1:0]);
    p5_r  <= p4_r;
    dg5_r <= dg4_r;
  end

  // stage 6: sum of partial products, radicand for the area root
  logic [FW:0]           mid;
  logic [0:0][ARW-1:0]   arad_r;
  logic [PW-1:0]         p6_r;
  logic                  dg6_r, v6_r;

  assign mid = (FW+1)'(hl_r) + (FW+1)'(lh_r);

  always_ff @(posedge clk) begin
    arad_r[0] <= (ARW'(hh_r) << FW) + (ARW'(mid) << PW) + ARW'(ll_r);
    p6_r      <= p5_r;
    dg6_r     <= dg5_r;
  end

  // area square root, one lane
  logic              av;
  logic [0:0][FW-1:0] aroot;
  logic              a_exact;

  tpa_sqrt_chain #(.LANES(1), .QW(FW)) u_area (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (v6_r),
    .rad_i  (arad_r),
    .v_o    (av),
    .root_o (aroot),
    .exact_o(a_exact)
  );

  // perimeter and flag ride alongside the area cells
  logic [PW-1:0] tp_r  [FW];
  logic          tdg_r [FW];

  always_ff @(posedge clk) begin
    tp_r[0]  <= p6_r;
    tdg_r[0] <= dg6_r;
    for (int k = 1; k < FW; k++) begin
      tp_r[k]  <= tp_r[k-1];
      tdg_r[k] <= tdg_r[k-1];
    end
  end

  // output register
  logic              out_strobe_r;
  tpa_out_t          out_data_r, out_data_nxt;
  logic [FW-1:0]     aq;

  assign aq = aroot[0] >> 2;

  always_comb begin
    out_data_nxt.perimeter  = PERIM_W'(tp_r[FW-1]);
    out_data_nxt.degenerate = tdg_r[FW-1];
    out_data_nxt.area       = tdg_r[FW-1] ? '0 : AREA_W'(aq);
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // valid bits; the exact flags only qualify nothing, kept for visibility of square inputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      v6_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v0_r         <= start;
      v1_r         <= v0_r;
      v2_r         <= v1_r;
      v3_r         <= sv | (sv & s_exact);
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      v6_r         <= v5_r;
      out_strobe_r <= av | (av & a_exact);
    end
  end

  assign busy       = 1'b0;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

[rtl/tpa_sqrt_cell.sv]
`timescale 1ns / 1ps
// one root bit per cell, restoring digit recurrence
module tpa_sqrt_cell #(
  parameter int LANES = 1,
  parameter int QW    = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            v_i,
  input  logic [LANES-1:0][QW+1:0]        rem_i,
  input  logic [LANES-1:0][QW-1:0]        root_i,
  input  logic [LANES-1:0][2*QW-1:0]      rad_i,
  output logic                            v_o,
  output logic [LANES-1:0][QW+1:0]        rem_o,
  output logic [LANES-1:0][QW-1:0]        root_o,
  output logic [LANES-1:0][2*QW-1:0]      rad_o
);

  logic                       v_r;
  logic [LANES-1:0][QW+1:0]   rem_r, rem_nxt;
  logic [LANES-1:0][QW-1:0]   root_r, root_nxt;
  logic [LANES-1:0][2*QW-1:0] rad_r, rad_nxt;

  always_comb begin
    logic [QW+1:0] sh;
    logic [QW+1:0] trial;
    for (int i = 0; i < LANES; i++) begin
      sh    = {rem_i[i][QW-1:0], rad_i[i][2*QW-1 -: 2]};
      trial = {root_i[i], 2'b01};
      if (sh >= trial) begin
        rem_nxt[i]  = sh - trial;
        root_nxt[i] = {root_i[i][QW-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = sh;
        root_nxt[i] = {root_i[i][QW-2:0], 1'b0};
      end
      rad_nxt[i] = {rad_i[i][2*QW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= rad_nxt;
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;

endmodule

[rtl/tpa_sqrt_chain.sv]
`timescale 1ns / 1ps
// QW cells in a row, radicand of 2*QW bits, root of QW bits
module tpa_sqrt_chain #(
  parameter int LANES = 1,
  parameter int QW    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       v_i,
  input  logic [LANES-1:0][2*QW-1:0] rad_i,
  output logic                       v_o,
  output logic [LANES-1:0][QW-1:0]   root_o,
  output logic                       exact_o
);

  logic                       v_w    [QW+1];
  logic [LANES-1:0][QW+1:0]   rem_w  [QW+1];
  logic [LANES-1:0][QW-1:0]   root_w [QW+1];
  logic [LANES-1:0][2*QW-1:0] rad_w  [QW+1];

  assign v_w[0]    = v_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = rad_i;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    tpa_sqrt_cell #(.LANES(LANES), .QW(QW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (v_w[k]),
      .rem_i (rem_w[k]),
      .root_i(root_w[k]),
      .rad_i (rad_w[k]),
      .v_o   (v_w[k+1]),
      .rem_o (rem_w[k+1]),
      .root_o(root_w[k+1]),
      .rad_o (rad_w[k+1])
    );
  end

  assign v_o     = v_w[QW];
  assign root_o  = root_w[QW];
  // remainder zero on every lane: perfect square, and radicand fully consumed
  assign exact_o = (rem_w[QW] == '0) && (rad_w[QW] == '0);

endmodule

[rtl/tpa_checker.sv]
`timescale 1ns / 1ps
module tpa_checker #(
  parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input tpa_pkg::tpa_in_t  in_data,
  input logic              out_strobe,
  input tpa_pkg::tpa_out_t out_data
);
  import tpa_pkg::*;

  localparam int LAT = (COORD_BITS + 5) + 2 * (COORD_BITS + 7) + 8;

  // pipeline never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every result traces back to an earlier request
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result without matching request");

  // flat triangles report no area
  a_degen_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.degenerate) |-> (out_data.area == '0))
    else $error("degenerate triangle with nonzero area");

  // a triangle that is not flat has a nonzero perimeter, checked while COORD_BITS <= COORD_W
  a_perim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.degenerate && COORD_BITS <= COORD_W) |->
      (out_data.perimeter != '0))
    else $error("proper triangle with zero perimeter");

endmodule

bind triangle_perimeter_area tpa_checker #(.COORD_BITS(COORD_BITS)) u_tpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);

[sim/tb_triangle_perimeter_area.sv]
`timescale 1ns / 1ps
module tb_triangle_perimeter_area;
  import tpa_pkg::*;

  // result expectations, oldest first
  class heron_scoreboard;
    tpa_out_t pending_results[$];
    int mismatches;

    function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function automatic logic [63:0] root128(logic [127:0] v);
      logic [63:0] r, t;
      logic [127:0] sq;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (64'd1 << b);
        sq = {64'd0, t} * {64'd0, t};
        if (sq <= v) r = t;
      end
      return r;
    endfunction

    function automatic logic [63:0] side_len(logic signed [15:0] x0, logic signed [15:0] y0,
                                             logic signed [15:0] x1, logic signed [15:0] y1);
      longint dx, dy;
      logic [63:0] s;
      dx = longint'(x0) - longint'(x1);
      dy = longint'(y0) - longint'(y1);
      s = (dx * dx + dy * dy);
      return root64(s << 8);
    endfunction

    function void note_request(tpa_in_t req);
      logic [63:0] a, b, c, p, f1, f2;
      logic [127:0] q;
      tpa_out_t res;
      a = side_len(req.ax, req.ay, req.bx, req.by_coord);
      b = side_len(req.ax, req.ay, req.cx, req.cy);
      c = side_len(req.bx, req.by_coord, req.cx, req.cy);
      p = a + b + c;
      res.degenerate = !(a + b > c && a + c > b && b + c > a);
      res.area = '0;
      if (!res.degenerate) begin
        f1 = p * (p - 2 * a);
        f2 = (p - 2 * b) * (p - 2 * c);
        q = {64'd0, f1} * {64'd0, f2};
        res.area = AREA_W'(root128(q) >> 2);
      end
      res.perimeter = PERIM_W'(p);
      pending_results.push_back(res);
    endfunction

    function void check_result(tpa_out_t got);
      tpa_out_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.perimeter !== exp_res.perimeter) begin
        $display("%0t: perimeter expected %0d actual %0d", $time, exp_res.perimeter,
                 got.perimeter);
        mismatches++;
      end
      if (got.area !== exp_res.area) begin
        $display("%0t: area expected %0d actual %0d", $time, exp_res.area, got.area);
        mismatches++;
      end
      if (got.degenerate !== exp_res.degenerate) begin
        $display("%0t: degenerate expected %0d actual %0d", $time, exp_res.degenerate,
                 got.degenerate);
        mismatches++;
      end
    endfunction
  endclass

  localparam int LATENCY = 75;
  localparam int STALL_LIMIT = 2000;

  logic clk, rst_n, start, busy, out_strobe;
  tpa_in_t in_data;
  tpa_out_t out_data;

  heron_scoreboard sb;
  int idle_pct;
  int quiet_cycles;
  int sent_count;
  int result_count;

  triangle_perimeter_area dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // sample everything at the edge; requests are noted when taken, results checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_request(in_data);
        sent_count++;
      end
      if (out_strobe) begin
        sb.check_result(out_data);
        result_count++;
      end
      // watchdog over cycles that move nothing
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("triangle_perimeter_area verification failed");
        $finish;
      end
    end
  end

  // push one request, with optional random gap before it
  task automatic send_request(tpa_in_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // one random coordinate: mostly small, sometimes full range or extreme
  function automatic logic [15:0] rand_coord(int span);
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return 16'($urandom);
      default: return 16'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  task automatic send_random(int count);
    tpa_in_t req;
    int span;
    for (int i = 0; i < count; i++) begin
      span = ($urandom_range(3) == 0) ? 32767 : (1 << $urandom_range(12, 2));
      req.ax = rand_coord(span); req.ay = rand_coord(span);
      req.bx = rand_coord(span); req.by_coord = rand_coord(span);
      // some collinear or coincident corners to hit the degenerate flag
      case ($urandom_range(7))
        0: begin req.cx = req.ax; req.cy = req.ay; end
        1: begin
          req.cx = req.bx + (req.bx - req.ax);
          req.cy = req.by_coord + (req.by_coord - req.ay);
        end
        default: begin req.cx = rand_coord(span); req.cy = rand_coord(span); end
      endcase
      send_request(req);
    end
  endtask

  task automatic send_directed();
    tpa_in_t req;
    logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    // all corners at one point
    req = '0; send_request(req);
    // right triangle 3-4-5 and a unit one
    req = '{16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 16'd4}; send_request(req);
    req = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1}; send_request(req);
    // collinear corners
    req = '{16'd0, 16'd0, 16'd5, 16'd5, 16'd10, 16'd10}; send_request(req);
    // two corners equal
    req = '{16'd7, 16'd7, 16'd7, 16'd7, 16'd1, 16'd9}; send_request(req);
    // extreme corners of the square, largest triangles
    req = '{16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff}; send_request(req);
    req = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff}; send_request(req);
    req = '{16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000}; send_request(req);
    // very thin triangle
    req = '{16'h8000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0001}; send_request(req);
    for (int i = 0; i < 12; i++) begin
      req.ax = ext[$urandom_range(3)]; req.ay = ext[$urandom_range(3)];
      req.bx = ext[$urandom_range(3)]; req.by_coord = ext[$urandom_range(3)];
      req.cx = ext[$urandom_range(3)]; req.cy = ext[$urandom_range(3)];
      send_request(req);
    end
  endtask

  initial begin
    int wait_cycles;
    sb = new();
    idle_pct = 0;
    quiet_cycles = 0;
    sent_count = 0;
    result_count = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 11;
    send_directed();
    send_random(600);
    // receiver cannot stall, so the second phase makes the sender the slow side
    idle_pct = 66;
    send_random(600);
    idle_pct = 0;
    send_random(630);
    start <= 1'b0;

    // drain the pipe, then allow the latency for any stray strobe
    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 20 * LATENCY) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * LATENCY) @(posedge clk);

    $display("sent %0d triangles (extreme, collinear, coincident, random) and checked %0d results",
             sent_count, result_count);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("triangle_perimeter_area verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_results.size());
      $display("triangle_perimeter_area verification failed");
    end
    $finish;
  end
endmodule
